>>> design/wsrt_pkg.sv
package wsrt_pkg;

    localparam int DEFAULT_TABLE_DEPTH = 64;

    localparam logic [1:0] CMD_INSERT = 2'd0;
    localparam logic [1:0] CMD_REMOVE = 2'd1;
    localparam logic [1:0] CMD_LOOKUP = 2'd2;

    localparam logic [1:0] STATUS_OK        = 2'd0;
    localparam logic [1:0] STATUS_EMPTY     = 2'd1;
    localparam logic [1:0] STATUS_NOT_FOUND = 2'd2;
    localparam logic [1:0] STATUS_FULL      = 2'd3;

    typedef struct packed {
        logic [15:0] code;
        logic [15:0] weight;
        logic [7:0]  sex;
    } record_t;

    localparam int RECORD_W = $bits(record_t);

endpackage

>>> design/wsrt_ram.sv
module wsrt_ram #(
    parameter int WIDTH = wsrt_pkg::RECORD_W,
    parameter int DEPTH = wsrt_pkg::DEFAULT_TABLE_DEPTH
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

>>> design/weight_sorted_record_table.sv
// Insert, remove and lookup walk the records held; a lookup ends at its first match, and
// full and unused requests do not walk the table. The single-read record RAM is walked one
// entry a cycle. One request at a time: the result waits in an output register while the
// next is taken.
// Reset (rst_n low, asynchronous) empties the table.
module weight_sorted_record_table #(
    parameter int TABLE_DEPTH = wsrt_pkg::DEFAULT_TABLE_DEPTH,
    localparam int IDX_W = $clog2(TABLE_DEPTH),
    localparam int CNT_W = $clog2(TABLE_DEPTH + 1)
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic [1:0]       command,
    input  logic [15:0]      code,
    input  logic [15:0]      weight,
    input  logic [7:0]       sex_char,
    output logic             out_valid,
    input  logic             out_ready,
    output logic [1:0]       status,
    output logic [15:0]      found_code,
    output logic [15:0]      found_weight,
    output logic [7:0]       found_sex,
    output logic [15:0]      heaviest_code,
    output logic [15:0]      heaviest_weight,
    output logic [7:0]       heaviest_sex,
    output logic [15:0]      lightest_code,
    output logic [15:0]      lightest_weight,
    output logic [7:0]       lightest_sex,
    output logic [CNT_W-1:0] record_count
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_SCAN  = 3'd1;
    localparam logic [2:0] S_WRNEW = 3'd2;
    localparam logic [2:0] S_FIN0  = 3'd3;
    localparam logic [2:0] S_FIN1  = 3'd4;
    localparam logic [2:0] S_FIN2  = 3'd5;
    localparam logic [2:0] S_LOAD  = 3'd6;

    logic [2:0]        state_reg, state_next;
    logic [1:0]        cmd_reg, cmd_next;
    logic [15:0]       key_reg, key_next;
    logic [15:0]       wt_reg, wt_next;
    logic [7:0]        sx_reg, sx_next;
    logic [CNT_W-1:0]  occ_reg, occ_next;
    logic [IDX_W-1:0]  iss_reg, iss_next;
    logic [CNT_W-1:0]  iss_left_reg, iss_left_next;
    logic              pend_reg, pend_next;
    logic [IDX_W-1:0]  pend_idx_reg, pend_idx_next;
    logic              matched_reg, matched_next;
    logic [IDX_W-1:0]  ins_pos_reg, ins_pos_next;
    logic [1:0]        status_reg, status_next;
    wsrt_pkg::record_t found_reg, found_next;
    wsrt_pkg::record_t heavy_reg, heavy_next;
    wsrt_pkg::record_t light_reg, light_next;

    logic              out_valid_reg, out_valid_next;
    logic [1:0]        out_status_reg, out_status_next;
    wsrt_pkg::record_t out_found_reg, out_found_next;
    wsrt_pkg::record_t out_heavy_reg, out_heavy_next;
    wsrt_pkg::record_t out_light_reg, out_light_next;
    logic [CNT_W-1:0]  out_count_reg, out_count_next;

    logic              ram_we;
    logic [IDX_W-1:0]  ram_waddr;
    wsrt_pkg::record_t ram_wdata;
    logic [IDX_W-1:0]  ram_raddr;
    wsrt_pkg::record_t ram_rdata;

    logic [IDX_W-1:0]  last_idx;
    logic              hit;
    logic              last;
    logic              finish;

    wsrt_ram #(
        .WIDTH (wsrt_pkg::RECORD_W),
        .DEPTH (TABLE_DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign last_idx = IDX_W'(occ_reg - 1'b1);
    assign hit      = (ram_rdata.code == key_reg);
    assign last     = (pend_idx_reg == last_idx);

    always_comb
    begin
        state_next      = state_reg;
        cmd_next        = cmd_reg;
        key_next        = key_reg;
        wt_next         = wt_reg;
        sx_next         = sx_reg;
        occ_next        = occ_reg;
        iss_next        = iss_reg;
        iss_left_next   = iss_left_reg;
        pend_next       = 1'b0;
        pend_idx_next   = pend_idx_reg;
        matched_next    = matched_reg;
        ins_pos_next    = ins_pos_reg;
        status_next     = status_reg;
        found_next      = found_reg;
        heavy_next      = heavy_reg;
        light_next      = light_reg;
        out_valid_next  = out_valid_reg && !out_ready;
        out_status_next = out_status_reg;
        out_found_next  = out_found_reg;
        out_heavy_next  = out_heavy_reg;
        out_light_next  = out_light_reg;
        out_count_next  = out_count_reg;
        ram_we          = 1'b0;
        ram_waddr       = pend_idx_reg;
        ram_wdata       = ram_rdata;
        ram_raddr       = iss_reg;
        finish          = 1'b0;
        in_ready        = (state_reg == S_IDLE);

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd_next     = command;
                    key_next     = code;
                    wt_next      = weight;
                    sx_next      = sex_char;
                    status_next  = wsrt_pkg::STATUS_OK;
                    found_next   = '0;
                    matched_next = 1'b0;
                    state_next   = S_FIN0;
                    unique case (command) inside
                        wsrt_pkg::CMD_INSERT:
                        begin
                            if (occ_reg == CNT_W'(TABLE_DEPTH))
                            begin
                                status_next = wsrt_pkg::STATUS_FULL;
                            end
                            else if (occ_reg == '0)
                            begin
                                ins_pos_next = '0;
                                state_next   = S_WRNEW;
                            end
                            else
                            begin
                                iss_next      = last_idx;
                                iss_left_next = occ_reg;
                                state_next    = S_SCAN;
                            end
                        end
                        wsrt_pkg::CMD_REMOVE, wsrt_pkg::CMD_LOOKUP:
                        begin
                            if (occ_reg == '0)
                            begin
                                status_next = wsrt_pkg::STATUS_EMPTY;
                            end
                            else
                            begin
                                iss_next      = '0;
                                iss_left_next = occ_reg;
                                state_next    = S_SCAN;
                            end
                        end
                        default:
                        begin
                            state_next = S_FIN0;
                        end
                    endcase
                end
            end

            S_SCAN:
            begin
                if (iss_left_reg != '0)
                begin
                    pend_next     = 1'b1;
                    pend_idx_next = iss_reg;
                    iss_left_next = iss_left_reg - 1'b1;
                    iss_next      = (cmd_reg == wsrt_pkg::CMD_INSERT) ? iss_reg - 1'b1
                                                                      : iss_reg + 1'b1;
                end
                if (pend_reg)
                begin
                    if (cmd_reg == wsrt_pkg::CMD_INSERT)
                    begin
                        // walk down from the tail, moving lighter-or-equal entries up
                        if (ram_rdata.weight > wt_reg)
                        begin
                            ins_pos_next = IDX_W'(pend_idx_reg + 1'b1);
                            finish       = 1'b1;
                        end
                        else
                        begin
                            ram_we    = 1'b1;
                            ram_waddr = IDX_W'(pend_idx_reg + 1'b1);
                            if (pend_idx_reg == '0)
                            begin
                                ins_pos_next = '0;
                                finish       = 1'b1;
                            end
                        end
                        if (finish)
                        begin
                            state_next = S_WRNEW;
                        end
                    end
                    else
                    begin
                        // on a remove, each entry after the match moves down one slot
                        if (!matched_reg && hit)
                        begin
                            matched_next = 1'b1;
                            found_next   = ram_rdata;
                            if (cmd_reg == wsrt_pkg::CMD_LOOKUP)
                            begin
                                finish = 1'b1;
                            end
                        end
                        else if (matched_reg && cmd_reg == wsrt_pkg::CMD_REMOVE)
                        begin
                            ram_we    = 1'b1;
                            ram_waddr = IDX_W'(pend_idx_reg - 1'b1);
                        end
                        if (last)
                        begin
                            finish = 1'b1;
                            if (!(matched_reg || hit))
                            begin
                                status_next = wsrt_pkg::STATUS_NOT_FOUND;
                            end
                            else if (cmd_reg == wsrt_pkg::CMD_REMOVE)
                            begin
                                occ_next = occ_reg - 1'b1;
                            end
                        end
                        if (finish)
                        begin
                            state_next = S_FIN0;
                        end
                    end
                    if (finish)
                    begin
                        pend_next     = 1'b0;
                        iss_left_next = '0;
                    end
                end
            end

            S_WRNEW:
            begin
                ram_we     = 1'b1;
                ram_waddr  = ins_pos_reg;
                ram_wdata  = '{code: key_reg, weight: wt_reg, sex: sx_reg};
                occ_next   = occ_reg + 1'b1;
                state_next = S_FIN0;
            end

            S_FIN0:
            begin
                ram_raddr = '0;
                if (occ_reg == '0)
                begin
                    heavy_next = '0;
                    light_next = '0;
                    state_next = S_LOAD;
                end
                else
                begin
                    state_next = S_FIN1;
                end
            end

            S_FIN1:
            begin
                ram_raddr  = last_idx;
                heavy_next = ram_rdata;
                state_next = S_FIN2;
            end

            S_FIN2:
            begin
                light_next = ram_rdata;
                state_next = S_LOAD;
            end

            S_LOAD:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = status_reg;
                    out_found_next  = found_reg;
                    out_heavy_next  = heavy_reg;
                    out_light_next  = light_reg;
                    out_count_next  = occ_reg;
                    state_next      = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            cmd_reg        <= '0;
            key_reg        <= '0;
            wt_reg         <= '0;
            sx_reg         <= '0;
            occ_reg        <= '0;
            iss_reg        <= '0;
            iss_left_reg   <= '0;
            pend_reg       <= 1'b0;
            pend_idx_reg   <= '0;
            matched_reg    <= 1'b0;
            ins_pos_reg    <= '0;
            status_reg     <= '0;
            found_reg      <= '0;
            heavy_reg      <= '0;
            light_reg      <= '0;
            out_valid_reg  <= 1'b0;
            out_status_reg <= '0;
            out_found_reg  <= '0;
            out_heavy_reg  <= '0;
            out_light_reg  <= '0;
            out_count_reg  <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            cmd_reg        <= cmd_next;
            key_reg        <= key_next;
            wt_reg         <= wt_next;
            sx_reg         <= sx_next;
            occ_reg        <= occ_next;
            iss_reg        <= iss_next;
            iss_left_reg   <= iss_left_next;
            pend_reg       <= pend_next;
            pend_idx_reg   <= pend_idx_next;
            matched_reg    <= matched_next;
            ins_pos_reg    <= ins_pos_next;
            status_reg     <= status_next;
            found_reg      <= found_next;
            heavy_reg      <= heavy_next;
            light_reg      <= light_next;
            out_valid_reg  <= out_valid_next;
            out_status_reg <= out_status_next;
            out_found_reg  <= out_found_next;
            out_heavy_reg  <= out_heavy_next;
            out_light_reg  <= out_light_next;
            out_count_reg  <= out_count_next;
        end
    end

    assign out_valid       = out_valid_reg;
    assign status          = out_status_reg;
    assign found_code      = out_found_reg.code;
    assign found_weight    = out_found_reg.weight;
    assign found_sex       = out_found_reg.sex;
    assign heaviest_code   = out_heavy_reg.code;
    assign heaviest_weight = out_heavy_reg.weight;
    assign heaviest_sex    = out_heavy_reg.sex;
    assign lightest_code   = out_light_reg.code;
    assign lightest_weight = out_light_reg.weight;
    assign lightest_sex    = out_light_reg.sex;
    assign record_count    = out_count_reg;

endmodule

>>> tb/tb_weight_sorted_record_table.sv
module tb_weight_sorted_record_table;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int TABLE_DEPTH = wsrt_pkg::DEFAULT_TABLE_DEPTH;
    localparam logic [1:0] CMD_UNUSED = 2'd3;
    localparam int LONG_HOLD_CYCLES = 400;
    localparam int SETTLE_CYCLES = 100;

    typedef struct packed {
        logic [1:0]        status;
        wsrt_pkg::record_t found;
        wsrt_pkg::record_t heaviest;
        wsrt_pkg::record_t lightest;
        logic [6:0]        count;
    } table_state_t;

    typedef struct {
        logic [1:0]        cmd;
        wsrt_pkg::record_t rec;
        bit                typed;
        table_state_t      want;
    } stim_row_t;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [1:0]  command;
    logic [15:0] code;
    logic [15:0] weight;
    logic [7:0]  sex_char;
    logic        out_valid;
    logic        out_ready;
    logic [1:0]  status;
    logic [15:0] found_code;
    logic [15:0] found_weight;
    logic [7:0]  found_sex;
    logic [15:0] heaviest_code;
    logic [15:0] heaviest_weight;
    logic [7:0]  heaviest_sex;
    logic [15:0] lightest_code;
    logic [15:0] lightest_weight;
    logic [7:0]  lightest_sex;
    logic [6:0]  record_count;

    wsrt_pkg::record_t table_rows [TABLE_DEPTH];
    int                table_fill;
    int                peak_fill;
    table_state_t      awaited_states [$];
    stim_row_t         directed_rows [$];

    int  error_count;
    int  results_seen;
    int  sent_count;
    int  cmd_count [4];
    int  status_count [4];
    bit  idling;
    bit  final_stretch;
    bit  hold_long_req;
    bit  hold_long_done;
    int  ready_stall;

    weight_sorted_record_table dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .command         (command),
        .code            (code),
        .weight          (weight),
        .sex_char        (sex_char),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .status          (status),
        .found_code      (found_code),
        .found_weight    (found_weight),
        .found_sex       (found_sex),
        .heaviest_code   (heaviest_code),
        .heaviest_weight (heaviest_weight),
        .heaviest_sex    (heaviest_sex),
        .lightest_code   (lightest_code),
        .lightest_weight (lightest_weight),
        .lightest_sex    (lightest_sex),
        .record_count    (record_count)
    );

    initial clk = 1'b0;
    always #10 clk = ~clk;

    initial
    begin
        #5_000_000;
        $display("simulation failed");
        $finish;
    end

    // sorted table update: one request in, the table snapshot it reports out
    function automatic table_state_t update_table(logic [1:0] cmd, wsrt_pkg::record_t rec);
        table_state_t r;
        int pos;
        int i;
        r = '0;
        r.status = wsrt_pkg::STATUS_OK;
        if (cmd == wsrt_pkg::CMD_INSERT)
        begin
            if (table_fill >= TABLE_DEPTH)
                r.status = wsrt_pkg::STATUS_FULL;
            else
            begin
                pos = 0;
                while (pos < table_fill && table_rows[pos].weight > rec.weight)
                    pos++;
                for (i = table_fill; i > pos; i--)
                    table_rows[i] = table_rows[i - 1];
                table_rows[pos] = rec;
                table_fill++;
            end
        end
        else if (cmd == wsrt_pkg::CMD_REMOVE || cmd == wsrt_pkg::CMD_LOOKUP)
        begin
            if (table_fill == 0)
                r.status = wsrt_pkg::STATUS_EMPTY;
            else
            begin
                pos = 0;
                while (pos < table_fill && table_rows[pos].code != rec.code)
                    pos++;
                if (pos == table_fill)
                    r.status = wsrt_pkg::STATUS_NOT_FOUND;
                else
                begin
                    r.found = table_rows[pos];
                    if (cmd == wsrt_pkg::CMD_REMOVE)
                    begin
                        for (i = pos; i < table_fill - 1; i++)
                            table_rows[i] = table_rows[i + 1];
                        table_fill--;
                    end
                end
            end
        end
        if (table_fill > 0)
        begin
            r.heaviest = table_rows[0];
            r.lightest = table_rows[table_fill - 1];
        end
        r.count = 7'(table_fill);
        return r;
    endfunction

    function automatic table_state_t mk_state(logic [1:0] st, wsrt_pkg::record_t f,
                                              wsrt_pkg::record_t h, wsrt_pkg::record_t l,
                                              int n);
        table_state_t r;
        r.status = st;
        r.found = f;
        r.heaviest = h;
        r.lightest = l;
        r.count = 7'(n);
        return r;
    endfunction

    task automatic add_row(logic [1:0] cmd, logic [15:0] c, logic [15:0] w, logic [7:0] s,
                           bit typed, table_state_t want);
        stim_row_t row;
        row.cmd = cmd;
        row.rec.code = c;
        row.rec.weight = w;
        row.rec.sex = s;
        row.typed = typed;
        row.want = want;
        directed_rows.push_back(row);
    endtask

    task automatic report_mismatch(string what, logic [15:0] got, logic [15:0] want);
        error_count++;
        $display("[%0t] result %0d %s: got %h, expected %h", $realtime, results_seen,
                 what, got, want);
    endtask

    task automatic check_field(string what, logic [15:0] got, logic [15:0] want);
        if (got !== want)
            report_mismatch(what, got, want);
    endtask

    // called right after a rising edge; returns at the edge that takes the request
    task automatic send_request(logic [1:0] cmd, wsrt_pkg::record_t rec, bit typed,
                                table_state_t want);
        table_state_t predicted;
        if (idling && $urandom_range(0, 3) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge clk);
        end
        in_valid <= 1'b1;
        command <= cmd;
        code <= rec.code;
        weight <= rec.weight;
        sex_char <= rec.sex;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        predicted = update_table(cmd, rec);
        awaited_states.push_back(typed ? want : predicted);
        cmd_count[cmd]++;
        status_count[predicted.status]++;
        if (table_fill > peak_fill)
            peak_fill = table_fill;
        sent_count++;
        idling <= !final_stretch && ((sent_count / 40) % 2 == 0);
    endtask

    function automatic logic [15:0] random_code();
        if ($urandom_range(0, 9) < 8)
            return 16'($urandom_range(0, 23));
        return 16'($urandom);
    endfunction

    function automatic logic [15:0] target_code();
        if (table_fill > 0 && $urandom_range(0, 9) < 6)
            return table_rows[$urandom_range(0, table_fill - 1)].code;
        return random_code();
    endfunction

    function automatic logic [15:0] random_weight();
        case ($urandom_range(0, 9)) inside
            0: return 16'h0000;
            1: return 16'hFFFF;
            [2:5]: return 16'(100 * $urandom_range(0, 7));
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic send_mixed();
        logic [1:0] cmd;
        wsrt_pkg::record_t rec;
        int sel;
        sel = $urandom_range(0, 19);
        if (sel < 8)
            cmd = wsrt_pkg::CMD_INSERT;
        else if (sel < 13)
            cmd = wsrt_pkg::CMD_REMOVE;
        else if (sel < 19)
            cmd = wsrt_pkg::CMD_LOOKUP;
        else
            cmd = CMD_UNUSED;
        rec.code = (cmd == wsrt_pkg::CMD_INSERT) ? random_code() : target_code();
        rec.weight = random_weight();
        rec.sex = 8'($urandom);
        send_request(cmd, rec, 1'b0, '0);
    endtask

    task automatic send_targeted(logic [1:0] cmd);
        wsrt_pkg::record_t rec;
        rec.code = (cmd == wsrt_pkg::CMD_INSERT) ? random_code() : target_code();
        rec.weight = random_weight();
        rec.sex = 8'($urandom);
        send_request(cmd, rec, 1'b0, '0);
    endtask

    // sender pause: hold off until every result is back
    task automatic wait_all_results();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (awaited_states.size() != 0);
    endtask

    // receiver: random stall bursts, plus one long hold to back up the block
    initial out_ready = 1'b0;
    always @(posedge clk)
    begin
        if (ready_stall != 0)
        begin
            ready_stall <= ready_stall - 1;
            out_ready <= 1'b0;
        end
        else if (hold_long_req && !hold_long_done)
        begin
            hold_long_done <= 1'b1;
            ready_stall <= LONG_HOLD_CYCLES - 1;
            out_ready <= 1'b0;
        end
        else if (idling && $urandom_range(0, 4) == 0)
        begin
            ready_stall <= $urandom_range(0, 8);
            out_ready <= 1'b0;
        end
        else
            out_ready <= 1'b1;
    end

    always @(posedge clk)
    begin : result_check
        table_state_t want;
        if (rst_n && out_valid && out_ready)
        begin
            results_seen++;
            if (awaited_states.size() == 0)
                report_mismatch("result with no request pending", 16'(status), 16'h0);
            else
            begin
                want = awaited_states.pop_front();
                check_field("status", 16'(status), 16'(want.status));
                check_field("found_code", found_code, want.found.code);
                check_field("found_weight", found_weight, want.found.weight);
                check_field("found_sex", 16'(found_sex), 16'(want.found.sex));
                check_field("heaviest_code", heaviest_code, want.heaviest.code);
                check_field("heaviest_weight", heaviest_weight, want.heaviest.weight);
                check_field("heaviest_sex", 16'(heaviest_sex), 16'(want.heaviest.sex));
                check_field("lightest_code", lightest_code, want.lightest.code);
                check_field("lightest_weight", lightest_weight, want.lightest.weight);
                check_field("lightest_sex", 16'(lightest_sex), 16'(want.lightest.sex));
                check_field("record_count", 16'(record_count), 16'(want.count));
            end
        end
    end

    initial
    begin
        wsrt_pkg::record_t r_max;
        wsrt_pkg::record_t r_zero;
        wsrt_pkg::record_t r_5555;
        int i;
        r_max = '{16'hFFFF, 16'hFFFF, 8'hFF};
        r_zero = '0;
        r_5555 = '{16'h5555, 16'hAAAA, 8'hAA};
        rst_n = 1'b0;
        in_valid = 1'b0;
        command = wsrt_pkg::CMD_INSERT;
        code = '0;
        weight = '0;
        sex_char = '0;
        idling = 1'b1;
        final_stretch = 1'b0;
        hold_long_req = 1'b0;
        hold_long_done = 1'b0;
        ready_stall = 0;
        error_count = 0;
        results_seen = 0;
        sent_count = 0;
        table_fill = 0;
        peak_fill = 0;
        for (i = 0; i < 4; i++)
        begin
            cmd_count[i] = 0;
            status_count[i] = 0;
        end

        add_row(wsrt_pkg::CMD_LOOKUP, 16'h0001, 16'h0000, 8'h00, 1'b1,
                mk_state(wsrt_pkg::STATUS_EMPTY, r_zero, r_zero, r_zero, 0));
        add_row(wsrt_pkg::CMD_REMOVE, 16'hFFFF, 16'hFFFF, 8'hFF, 1'b1,
                mk_state(wsrt_pkg::STATUS_EMPTY, r_zero, r_zero, r_zero, 0));
        add_row(CMD_UNUSED, 16'h0000, 16'h0000, 8'h00, 1'b1,
                mk_state(wsrt_pkg::STATUS_OK, r_zero, r_zero, r_zero, 0));
        add_row(wsrt_pkg::CMD_INSERT, 16'hFFFF, 16'hFFFF, 8'hFF, 1'b1,
                mk_state(wsrt_pkg::STATUS_OK, r_zero, r_max, r_max, 1));
        add_row(wsrt_pkg::CMD_LOOKUP, 16'hFFFF, 16'h0000, 8'h00, 1'b1,
                mk_state(wsrt_pkg::STATUS_OK, r_max, r_max, r_max, 1));
        add_row(wsrt_pkg::CMD_LOOKUP, 16'h0000, 16'hFFFF, 8'hFF, 1'b1,
                mk_state(wsrt_pkg::STATUS_NOT_FOUND, r_zero, r_max, r_max, 1));
        add_row(wsrt_pkg::CMD_INSERT, 16'h0000, 16'h0000, 8'h00, 1'b1,
                mk_state(wsrt_pkg::STATUS_OK, r_zero, r_max, r_zero, 2));
        // equal weights: newer goes first; duplicate code: first match wins
        add_row(wsrt_pkg::CMD_INSERT, 16'h1234, 16'h8000, 8'h4D, 1'b0, '0);
        add_row(wsrt_pkg::CMD_INSERT, 16'h5678, 16'h8000, 8'h46, 1'b0, '0);
        add_row(wsrt_pkg::CMD_INSERT, 16'h1234, 16'h0001, 8'hAA, 1'b0, '0);
        add_row(wsrt_pkg::CMD_LOOKUP, 16'h1234, 16'h0000, 8'h00, 1'b0, '0);
        add_row(wsrt_pkg::CMD_REMOVE, 16'h1234, 16'h0000, 8'h00, 1'b0, '0);
        add_row(wsrt_pkg::CMD_LOOKUP, 16'h1234, 16'h0000, 8'h00, 1'b0, '0);
        add_row(CMD_UNUSED, 16'hFFFF, 16'hFFFF, 8'hFF, 1'b0, '0);
        add_row(wsrt_pkg::CMD_REMOVE, 16'h5678, 16'h0000, 8'h00, 1'b0, '0);
        add_row(wsrt_pkg::CMD_INSERT, 16'hAAAA, 16'h5555, 8'h55, 1'b0, '0);
        add_row(wsrt_pkg::CMD_INSERT, 16'h5555, 16'hAAAA, 8'hAA, 1'b0, '0);
        add_row(wsrt_pkg::CMD_REMOVE, 16'h9999, 16'h0000, 8'h00, 1'b0, '0);
        add_row(wsrt_pkg::CMD_REMOVE, 16'hFFFF, 16'h0000, 8'h00, 1'b0, '0);
        add_row(wsrt_pkg::CMD_REMOVE, 16'h0000, 16'h0000, 8'h00, 1'b0, '0);
        add_row(wsrt_pkg::CMD_REMOVE, 16'h1234, 16'h0000, 8'h00, 1'b0, '0);
        add_row(wsrt_pkg::CMD_REMOVE, 16'hAAAA, 16'h0000, 8'h00, 1'b0, '0);
        add_row(wsrt_pkg::CMD_REMOVE, 16'h5555, 16'h0000, 8'h00, 1'b1,
                mk_state(wsrt_pkg::STATUS_OK, r_5555, r_zero, r_zero, 0));
        add_row(wsrt_pkg::CMD_LOOKUP, 16'h5555, 16'h0000, 8'h00, 1'b1,
                mk_state(wsrt_pkg::STATUS_EMPTY, r_zero, r_zero, r_zero, 0));

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        foreach (directed_rows[k])
            send_request(directed_rows[k].cmd, directed_rows[k].rec, directed_rows[k].typed,
                         directed_rows[k].want);

        for (i = 0; i < 200; i++)
            send_mixed();
        wait_all_results();

        // fill to the top and push past it while the receiver holds off
        hold_long_req = 1'b1;
        while (table_fill < TABLE_DEPTH)
            send_targeted(wsrt_pkg::CMD_INSERT);
        repeat (4)
            send_targeted(wsrt_pkg::CMD_INSERT);

        while (table_fill > 6)
            send_targeted(($urandom_range(0, 9) < 7) ? wsrt_pkg::CMD_REMOVE
                                                      : wsrt_pkg::CMD_LOOKUP);
        wait_all_results();

        final_stretch = 1'b1;
        idling <= 1'b0;
        for (i = 0; i < 120; i++)
            send_mixed();

        in_valid <= 1'b0;
        while (awaited_states.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("%0d requests sent: %0d insert, %0d remove, %0d lookup, %0d unused command",
                 sent_count, cmd_count[wsrt_pkg::CMD_INSERT], cmd_count[wsrt_pkg::CMD_REMOVE],
                 cmd_count[wsrt_pkg::CMD_LOOKUP], cmd_count[CMD_UNUSED]);
        $display("outcomes: %0d ok, %0d empty, %0d not found, %0d full; peak %0d of %0d rows",
                 status_count[wsrt_pkg::STATUS_OK], status_count[wsrt_pkg::STATUS_EMPTY],
                 status_count[wsrt_pkg::STATUS_NOT_FOUND], status_count[wsrt_pkg::STATUS_FULL],
                 peak_fill, TABLE_DEPTH);
        if (error_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
